@@ rtl/bol_pkg.sv @@
// Shared types and constants for the bounded ordered list unit.
package bol_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = CNT_W;
  localparam int VAL_W = 32;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_BACK  = 3'd0,
    K_PUSH_FRONT = 3'd1,
    K_POP_BACK   = 3'd2,
    K_POP_FRONT  = 3'd3,
    K_INSERT     = 3'd4,
    K_ERASE      = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Broadcast to every cell: one shift operation.
  typedef struct packed {
    logic ins;
    logic del;
    cnt_t pos;
    cnt_t cnt;
    val_t val;
  } cmd_t;

endpackage

@@ rtl/bol_if.sv @@
// Valid/ready channel interfaces for operation and result items.
interface bol_in_if;
  logic                          valid;
  logic                          ready;
  logic [bol_pkg::KIND_W-1:0]    kind;
  logic [bol_pkg::POS_W-1:0]     position;
  logic signed [bol_pkg::VAL_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface bol_out_if;
  logic                             valid;
  logic                             ready;
  logic [bol_pkg::STAT_W-1:0]       status;
  logic [bol_pkg::CNT_W-1:0]        count;
  logic signed [bol_pkg::VAL_W-1:0] front_value;
  logic signed [bol_pkg::VAL_W-1:0] back_value;
  logic signed [bol_pkg::VAL_W-1:0] removed_value;

  modport source (output valid, status, count, front_value, back_value, removed_value,
                  input ready);
  modport sink   (input valid, status, count, front_value, back_value, removed_value,
                  output ready);
endinterface

@@ rtl/bol_cell.sv @@
// One list cell: holds an element and shifts with its neighbors.
module bol_cell (
  input  logic          clk,
  input  bol_pkg::cmd_t cmd,
  input  bol_pkg::cnt_t idx,
  input  bol_pkg::cnt_t tail,
  input  bol_pkg::val_t left_i,
  input  bol_pkg::val_t right_i,
  output bol_pkg::val_t value_o,
  output bol_pkg::val_t tap_o,
  output bol_pkg::val_t rm_o
);

  bol_pkg::val_t value_r;
  bol_pkg::val_t value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (cmd.ins) begin
      if (idx == cmd.pos) begin
        value_nxt = cmd.val;
      end else if (idx > cmd.pos && idx <= cmd.cnt) begin
        value_nxt = left_i;
      end
    end else if (cmd.del && idx >= cmd.pos) begin
      value_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins || cmd.del) begin
      value_r <= value_nxt;
    end
  end

  assign value_o = value_r;
  // Gated contributions, OR-combined across the row.
  assign tap_o   = (idx == tail) ? value_r : '0;
  assign rm_o    = (cmd.del && idx == cmd.pos) ? value_r : '0;

endmodule

@@ rtl/bol_chain.sv @@
// Row of list cells with the front, back and removed-element taps.
module bol_chain (
  input  logic          clk,
  input  bol_pkg::cmd_t cmd,
  input  bol_pkg::cnt_t tail,
  output bol_pkg::val_t front_o,
  output bol_pkg::val_t back_o,
  output bol_pkg::val_t removed_o
);

  bol_pkg::val_t val_w [bol_pkg::DEPTH];
  bol_pkg::val_t tap_w [bol_pkg::DEPTH];
  bol_pkg::val_t rm_w  [bol_pkg::DEPTH];

  for (genvar i = 0; i < bol_pkg::DEPTH; i++) begin : g_cell
    bol_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .idx     (bol_pkg::CNT_W'(i)),
      .tail    (tail),
      .left_i  ((i == 0) ? val_w[i] : val_w[(i == 0) ? 0 : i - 1]),
      .right_i ((i == bol_pkg::DEPTH - 1) ? val_w[i]
                : val_w[(i == bol_pkg::DEPTH - 1) ? i : i + 1]),
      .value_o (val_w[i]),
      .tap_o   (tap_w[i]),
      .rm_o    (rm_w[i])
    );
  end

  always_comb begin
    back_o    = '0;
    removed_o = '0;
    for (int i = 0; i < bol_pkg::DEPTH; i++) begin
      back_o    = back_o | tap_w[i];
      removed_o = removed_o | rm_w[i];
    end
  end

  assign front_o = val_w[0];

endmodule

@@ rtl/bounded_ordered_list_insert_erase_unit.sv @@
// Top level of the bounded ordered list: decode, count and result staging.
// Ordered list of up to DEPTH signed 32-bit elements held in a row of cells.
// For each operation item, in the accept cycle every cell shifts or loads in
// parallel and the removed element is captured; once the output register is free
// or being read, the front and back taps of the row are gathered into it.
// A new item is taken once that gather step has moved into the output register.
// Reset clears the element count and the valid flags; cells hold undefined data until written.
module bounded_ordered_list_insert_erase_unit (
  input  logic  clk,
  input  logic  rst_n,
  bol_in_if.sink    in_ch,
  bol_out_if.source out_ch
);

  bol_pkg::cnt_t    count_r;
  bol_pkg::cnt_t    count_nxt;
  logic             p_valid_r;
  bol_pkg::status_t p_status_r;
  bol_pkg::val_t    p_removed_r;
  logic             out_valid_r;
  bol_pkg::status_t out_status_r;
  bol_pkg::cnt_t    out_count_r;
  bol_pkg::val_t    out_front_r;
  bol_pkg::val_t    out_back_r;
  bol_pkg::val_t    out_removed_r;

  bol_pkg::status_t st;
  bol_pkg::cmd_t    cmd;
  bol_pkg::val_t    front_w;
  bol_pkg::val_t    back_w;
  bol_pkg::val_t    removed_w;
  logic             accept;
  logic             move;
  logic             full;
  logic             empty;
  logic             ins_ok;
  logic             del_ok;
  bol_pkg::cnt_t    op_pos;

  assign in_ch.ready = !p_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign move        = p_valid_r && (!out_valid_r || out_ch.ready);
  assign full        = (count_r >= bol_pkg::CNT_W'(bol_pkg::DEPTH));
  assign empty       = (count_r == '0);

  always_comb begin
    st     = bol_pkg::ST_OK;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    op_pos = '0;
    case (in_ch.kind)
      bol_pkg::K_PUSH_BACK: begin
        if (full) st = bol_pkg::ST_FULL;
        else begin
          ins_ok = 1'b1;
          op_pos = count_r;
        end
      end
      bol_pkg::K_PUSH_FRONT: begin
        if (full) st = bol_pkg::ST_FULL;
        else ins_ok = 1'b1;
      end
      bol_pkg::K_POP_BACK: begin
        if (empty) st = bol_pkg::ST_EMPTY;
        else begin
          del_ok = 1'b1;
          op_pos = count_r - bol_pkg::CNT_W'(1);
        end
      end
      bol_pkg::K_POP_FRONT: begin
        if (empty) st = bol_pkg::ST_EMPTY;
        else del_ok = 1'b1;
      end
      bol_pkg::K_INSERT: begin
        // range check comes before the full check
        if (in_ch.position > count_r) st = bol_pkg::ST_RANGE;
        else if (full) st = bol_pkg::ST_FULL;
        else begin
          ins_ok = 1'b1;
          op_pos = in_ch.position;
        end
      end
      bol_pkg::K_ERASE: begin
        if (in_ch.position >= count_r) st = bol_pkg::ST_RANGE;
        else begin
          del_ok = 1'b1;
          op_pos = in_ch.position;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd.ins = accept && ins_ok;
    cmd.del = accept && del_ok;
    cmd.pos = op_pos;
    cmd.cnt = count_r;
    cmd.val = in_ch.value;
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) count_nxt = count_r + bol_pkg::CNT_W'(1);
    else if (cmd.del) count_nxt = count_r - bol_pkg::CNT_W'(1);
  end

  bol_chain u_chain (
    .clk       (clk),
    .cmd       (cmd),
    .tail      (count_r - bol_pkg::CNT_W'(1)),
    .front_o   (front_w),
    .back_o    (back_w),
    .removed_o (removed_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) p_valid_r <= 1'b1;
      else if (move) p_valid_r <= 1'b0;
      if (move) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_status_r  <= st;
      p_removed_r <= removed_w;
    end
    // cells already hold the post-operation list while the item is pending
    if (move) begin
      out_status_r  <= p_status_r;
      out_count_r   <= count_r;
      out_front_r   <= empty ? '0 : front_w;
      out_back_r    <= empty ? '0 : back_w;
      out_removed_r <= p_removed_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.count         = out_count_r;
  assign out_ch.front_value   = out_front_r;
  assign out_ch.back_value    = out_back_r;
  assign out_ch.removed_value = out_removed_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bol_pkg::CNT_W'(bol_pkg::DEPTH))
    else $error("element count above capacity");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && st != bol_pkg::ST_OK) |=> (count_r == $past(count_r)))
    else $error("rejected item changed the count");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> (count_r == $past(count_r) + bol_pkg::CNT_W'(1)))
    else $error("insert did not grow the list");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == bol_pkg::ST_EMPTY) |-> (out_count_r == '0))
    else $error("empty status with nonzero count");

endmodule

@@ tb/sv/bounded_ordered_list_insert_erase_unit_tb.sv @@
// Self-checking testbench for the bounded ordered list unit: directed, back-pressure and random ops.
module bounded_ordered_list_insert_erase_unit_tb;

  localparam logic [bol_pkg::KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [bol_pkg::KIND_W-1:0] KIND_UNUSED_7 = 3'd7;
  localparam bol_pkg::val_t VAL_MAX = 32'sh7FFF_FFFF;
  localparam bol_pkg::val_t VAL_MIN = 32'sh8000_0000;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_LEN = 150;
  localparam int REPORT_MAX = 10;
  localparam int ITEMS_PER_PHASE = 400;

  typedef struct {
    bol_pkg::status_t status;
    bol_pkg::cnt_t    count;
    bol_pkg::val_t    front;
    bol_pkg::val_t    back;
    bol_pkg::val_t    removed;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bol_in_if  in_if ();
  bol_out_if out_if ();

  bounded_ordered_list_insert_erase_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  always #10 clk = ~clk;

  // Shadow copy of the list contents.
  bol_pkg::val_t list_cells [bol_pkg::DEPTH];
  int   list_len = 0;

  list_result_t expected_results [$];
  int mismatches = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_trigger = 0;

  function automatic bol_pkg::val_t remove_cell(int pos);
    bol_pkg::val_t gone;
    gone = list_cells[pos];
    for (int i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i + 1];
    list_len--;
    return gone;
  endfunction

  function automatic void open_gap(int pos);
    for (int i = list_len; i > pos; i--) list_cells[i] = list_cells[i - 1];
  endfunction

  function automatic list_result_t apply_list_op(logic [bol_pkg::KIND_W-1:0] kind,
                                                 bol_pkg::cnt_t pos, bol_pkg::val_t val);
    list_result_t r;
    r.status  = bol_pkg::ST_OK;
    r.removed = '0;
    case (kind)
      bol_pkg::K_PUSH_BACK: begin
        if (list_len >= bol_pkg::DEPTH) r.status = bol_pkg::ST_FULL;
        else begin
          list_cells[list_len] = val;
          list_len++;
        end
      end
      bol_pkg::K_PUSH_FRONT: begin
        if (list_len >= bol_pkg::DEPTH) r.status = bol_pkg::ST_FULL;
        else begin
          open_gap(0);
          list_cells[0] = val;
          list_len++;
        end
      end
      bol_pkg::K_POP_BACK: begin
        if (list_len == 0) r.status = bol_pkg::ST_EMPTY;
        else r.removed = remove_cell(list_len - 1);
      end
      bol_pkg::K_POP_FRONT: begin
        if (list_len == 0) r.status = bol_pkg::ST_EMPTY;
        else r.removed = remove_cell(0);
      end
      bol_pkg::K_INSERT: begin
        // range check wins over the full check
        if (int'(pos) > list_len) r.status = bol_pkg::ST_RANGE;
        else if (list_len >= bol_pkg::DEPTH) r.status = bol_pkg::ST_FULL;
        else begin
          open_gap(int'(pos));
          list_cells[pos] = val;
          list_len++;
        end
      end
      bol_pkg::K_ERASE: begin
        if (int'(pos) >= list_len) r.status = bol_pkg::ST_RANGE;
        else r.removed = remove_cell(int'(pos));
      end
      default: ;
    endcase
    r.count = bol_pkg::cnt_t'(list_len);
    r.front = (list_len != 0) ? list_cells[0] : '0;
    r.back  = (list_len != 0) ? list_cells[list_len - 1] : '0;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch on %s: expected %h, got %h", name, exp_v, act_v);
    end
  endtask

  // Predict on accepted ops, then compare accepted results with the oldest prediction.
  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        expected_results.push_back(apply_list_op(in_if.kind, in_if.position, in_if.value));
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: result item with nothing expected, count %0d", out_if.count);
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", 32'(exp_r.status), 32'(out_if.status));
          check_field("count", 32'(exp_r.count), 32'(out_if.count));
          check_field("front_value", exp_r.front, out_if.front_value);
          check_field("back_value", exp_r.back, out_if.back_value);
          check_field("removed_value", exp_r.removed, out_if.removed_value);
        end
      end
    end
  end

  // Result-side ready: random stalls, plus a long hold-off on request.
  initial begin : result_ready_driver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_LEN;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic bol_pkg::val_t random_value();
    case ($urandom_range(7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return -32'sd1;
      default: return bol_pkg::val_t'($urandom);
    endcase
  endfunction

  task automatic send_op(logic [bol_pkg::KIND_W-1:0] kind, bol_pkg::cnt_t pos,
                         bol_pkg::val_t val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.kind     <= kind;
    in_if.position <= pos;
    in_if.value    <= val;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_results_done();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_ops(int n);
    logic [bol_pkg::KIND_W-1:0] kind;
    int grow_pct;
    int roll;
    int top;
    bol_pkg::cnt_t pos;
    for (int i = 0; i < n; i++) begin
      // alternate growing and shrinking so the list sweeps empty to full
      grow_pct = ((i / 40) % 2 == 0) ? 75 : 25;
      roll = $urandom_range(99);
      if (roll < 2) begin
        kind = (roll == 0) ? KIND_UNUSED_6 : KIND_UNUSED_7;
      end else if ($urandom_range(99) < grow_pct) begin
        case ($urandom_range(2))
          0: kind = bol_pkg::K_PUSH_BACK;
          1: kind = bol_pkg::K_PUSH_FRONT;
          default: kind = bol_pkg::K_INSERT;
        endcase
      end else begin
        case ($urandom_range(2))
          0: kind = bol_pkg::K_POP_BACK;
          1: kind = bol_pkg::K_POP_FRONT;
          default: kind = bol_pkg::K_ERASE;
        endcase
      end
      // mostly near the live range; shadow count may lag by an item or two
      top = (list_len + 1 > bol_pkg::DEPTH) ? bol_pkg::DEPTH : list_len + 1;
      if ($urandom_range(99) < 80) pos = bol_pkg::cnt_t'($urandom_range(top));
      else pos = bol_pkg::cnt_t'($urandom_range(bol_pkg::DEPTH));
      send_op(kind, pos, random_value());
    end
  endtask

  task automatic test_special_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_op(bol_pkg::K_POP_BACK, '0, '0);                     // empty
    send_op(bol_pkg::K_POP_FRONT, '0, '0);                    // empty
    send_op(bol_pkg::K_ERASE, '0, VAL_MAX);                   // erase on empty list
    send_op(bol_pkg::K_INSERT, bol_pkg::cnt_t'(1), VAL_MAX);  // insert past the end
    send_op(bol_pkg::K_INSERT, '0, '0);
    send_op(bol_pkg::K_PUSH_BACK, bol_pkg::cnt_t'(bol_pkg::DEPTH), VAL_MAX);
    send_op(bol_pkg::K_PUSH_FRONT, bol_pkg::cnt_t'(bol_pkg::DEPTH), VAL_MIN);
    send_op(bol_pkg::K_INSERT, bol_pkg::cnt_t'(3), -32'sd1);  // insert at count appends
    send_op(bol_pkg::K_ERASE, bol_pkg::cnt_t'(4), '0);        // erase at count
    send_op(KIND_UNUSED_6, bol_pkg::cnt_t'(2), VAL_MAX);
    send_op(KIND_UNUSED_7, bol_pkg::cnt_t'(bol_pkg::DEPTH), VAL_MIN);
    send_op(bol_pkg::K_INSERT, bol_pkg::cnt_t'(1), 32'sh5A5A_A5A5);
    send_op(bol_pkg::K_ERASE, bol_pkg::cnt_t'(2), '0);
    send_op(bol_pkg::K_POP_BACK, '0, '0);
    send_op(bol_pkg::K_POP_FRONT, '0, '0);
    send_op(bol_pkg::K_ERASE, bol_pkg::cnt_t'(1), '0);
    send_op(bol_pkg::K_POP_BACK, '0, '0);
    send_op(bol_pkg::K_POP_FRONT, '0, '0);                    // empty again
    wait_results_done();
  endtask

  task automatic test_capacity();
    int start_len;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    start_len = list_len;
    for (int i = start_len; i < bol_pkg::DEPTH; i++)
      send_op(bol_pkg::K_PUSH_FRONT, '0, random_value());
    send_op(bol_pkg::K_PUSH_BACK, '0, VAL_MAX);               // full
    send_op(bol_pkg::K_PUSH_FRONT, '0, VAL_MIN);              // full
    // at count on a full list: full
    send_op(bol_pkg::K_INSERT, bol_pkg::cnt_t'(bol_pkg::DEPTH), VAL_MAX);
    send_op(bol_pkg::K_INSERT, bol_pkg::cnt_t'(5), VAL_MIN);  // full
    send_op(bol_pkg::K_ERASE, bol_pkg::cnt_t'(bol_pkg::DEPTH), '0);  // range
    send_op(bol_pkg::K_ERASE, bol_pkg::cnt_t'(bol_pkg::DEPTH - 1), '0);
    // one past the end: range
    send_op(bol_pkg::K_INSERT, bol_pkg::cnt_t'(bol_pkg::DEPTH), VAL_MAX);
    send_op(bol_pkg::K_INSERT, bol_pkg::cnt_t'(bol_pkg::DEPTH - 1), VAL_MIN);
    for (int i = 0; i < bol_pkg::DEPTH; i++)
      send_op(bol_pkg::K_ERASE, bol_pkg::cnt_t'($urandom_range(bol_pkg::DEPTH - 1 - i)), '0);
    send_op(bol_pkg::K_POP_FRONT, '0, '0);
    wait_results_done();
  endtask

  task automatic test_back_pressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_trigger++;
    send_random_ops(40);
    wait_results_done();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    send_random_ops(ITEMS_PER_PHASE);
    wait_results_done();
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.kind     <= bol_pkg::K_PUSH_BACK;
    in_if.position <= '0;
    in_if.value    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_cases();
    test_capacity();
    test_back_pressure();
    test_random_traffic(0, 0);
    test_random_traffic(85, 0);
    test_random_traffic(0, 85);
    test_random_traffic(27, 27);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bol_pkg.sv
rtl/bol_if.sv
rtl/bol_cell.sv
rtl/bol_chain.sv
rtl/bounded_ordered_list_insert_erase_unit.sv
tb/sv/bounded_ordered_list_insert_erase_unit_tb.sv
